// ===== hw/rtl/utf8_stream_decoder_validator_top_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_VALIDATOR_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_VALIDATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define UTF8SDV_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define UTF8SDV_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/utf8sdv_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Field widths, byte patterns and the lead byte decode.
// ----------------------------------------------------------------------------
package utf8sdv_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 31;
   localparam int unsigned REM_W  = 3;
   localparam int unsigned LEAD_W = 7;

   // Sequence lengths
   localparam logic [REM_W-1:0] LEN_BAD = 3'd0;
   localparam logic [REM_W-1:0] LEN_ONE = 3'd1;

   // Continuation tag (top two bits)
   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef struct packed {
      logic [REM_W-1:0]  len;
      logic [LEAD_W-1:0] mask;
   } lead_info_type;

   function automatic lead_info_type lead_decode(input logic [BYTE_W-1:0] c);
      lead_info_type info;
      casez (c)
         8'b0???????: info = '{len: 3'd1, mask: 7'h7F};
         8'b110?????: info = '{len: 3'd2, mask: 7'h1F};
         8'b1110????: info = '{len: 3'd3, mask: 7'h0F};
         8'b11110???: info = '{len: 3'd4, mask: 7'h07};
         8'b111110??: info = '{len: 3'd5, mask: 7'h03};
         8'b1111110?: info = '{len: 3'd6, mask: 7'h01};
         default:     info = '{len: LEN_BAD, mask: 7'h00};
      endcase
      return info;
   endfunction

endpackage

// ===== hw/rtl/utf8_stream_decoder_validator_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder and validator
// Decodes a byte stream into code points and reports per-string validity.
// ----------------------------------------------------------------------------
// One byte goes in per transfer and exactly one result comes out per byte,
// in the next cycle, from a result register. The block takes one byte every
// clock as long as the result side keeps up: req_ready is high whenever the
// result register is empty or its result is being taken in the same cycle,
// so throughput is one byte per clock. The decode
// state (bytes still expected, gathered code point bits, sticky error) is
// updated at each input transfer. A result with rsp_string_end high closes
// the string, carries its validity and clears all decode state. Sequences of
// 1 to 6 bytes are decoded; no overlong or surrogate checks are made. Write
// csr_wr_data to the null policy bit (1 lets zero bytes through as characters)
// only while the block is idle.
module utf8_stream_decoder_validator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [utf8sdv_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_char_done,
   output logic [utf8sdv_pkg::CP_W-1:0]      rsp_code_point,
   output logic                              rsp_string_end,
   output logic                              rsp_string_valid
);
   import utf8sdv_pkg::*;

   // Configuration
   logic              null_ok_ff;

   // Decode state
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [CP_W-1:0]   part_ff, part_in;
   logic              err_ff,  err_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              done_ff,  done_in;
   logic [CP_W-1:0]   cp_ff,    cp_in;
   logic              end_ff,   end_in;
   logic              sval_ff,  sval_in;

   logic              accept;
   lead_info_type     lead;

   // Accept while the result slot is free or draining this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign lead      = lead_decode(req_data_byte);

   always_comb begin
      rem_in  = rem_ff;
      part_in = part_ff;
      err_in  = err_ff;
      done_in = 1'b0;
      cp_in   = '0;
      end_in  = 1'b0;
      sval_in = 1'b0;

      if (rem_ff == '0) begin
         // Expect a lead byte.
         if (lead.len == LEN_BAD) begin
            err_in = 1'b1;
         end else if (lead.len == LEN_ONE) begin
            if (req_data_byte == '0 && !null_ok_ff) begin
               err_in = 1'b1;
            end else begin
               done_in = 1'b1;
               cp_in   = CP_W'(req_data_byte);
            end
         end else begin
            part_in = CP_W'(req_data_byte[LEAD_W-1:0] & lead.mask);
            rem_in  = lead.len - 3'd1;
         end
      end else begin
         if (req_data_byte[7:6] != CONT_TAG) begin
            // Bad continuation: drop the open sequence, consume the byte.
            err_in  = 1'b1;
            rem_in  = '0;
            part_in = '0;
         end else begin
            // Shift in six more bits; bits past the code point width fall off.
            part_in = {part_ff[CP_W-7:0], req_data_byte[5:0]};
            rem_in  = rem_ff - 3'd1;
            if (rem_in == '0) begin
               done_in = 1'b1;
               cp_in   = part_in;
               part_in = '0;
            end
         end
      end

      if (req_last_byte) begin
         // Close the string: an open sequence makes it invalid.
         if (rem_in != '0) begin
            err_in = 1'b1;
         end
         end_in  = 1'b1;
         sval_in = !err_in;
         rem_in  = '0;
         part_in = '0;
         err_in  = 1'b0;
      end
   end

   // Hold the result until taken; load a new one on each input transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         null_ok_ff    <= 1'b0;
         rem_ff        <= '0;
         part_ff       <= '0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            null_ok_ff <= csr_wr_data;
         end
         if (accept) begin
            rem_ff  <= rem_in;
            part_ff <= part_in;
            err_ff  <= err_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff <= done_in;
         cp_ff   <= cp_in;
         end_ff  <= end_in;
         sval_ff <= sval_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_done    = done_ff;
   assign rsp_code_point   = cp_ff;
   assign rsp_string_end   = end_ff;
   assign rsp_string_valid = sval_ff;

endmodule

// ===== hw/rtl/utf8sdv_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_validator_top_defines.svh"

module utf8sdv_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_last_byte,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_char_done,
   input logic [utf8sdv_pkg::CP_W-1:0]   rsp_code_point,
   input logic                           rsp_string_end,
   input logic                           rsp_string_valid
);
   import utf8sdv_pkg::*;

   // Validity is only reported on the closing result.
   `UTF8SDV_ASSERT_NOW(a_valid_only_at_end, clock, reset,
      rsp_valid && rsp_string_valid, rsp_string_end, "string_valid without string_end")

   // No code point without a completed character.
   `UTF8SDV_ASSERT_NOW(a_cp_zero_idle, clock, reset,
      rsp_valid && !rsp_char_done, rsp_code_point == '0, "code_point set without char_done")

   // An input transfer always yields a result in the next cycle.
   `UTF8SDV_ASSERT_NEXT(a_one_result, clock, reset,
      req_valid && req_ready, rsp_valid && rsp_string_end == $past(req_last_byte),
      "result missing or string_end mismatch")

   // A stalled result holds.
   `UTF8SDV_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_code_point) && $stable(rsp_string_end),
      "stalled result changed")

endmodule

bind utf8_stream_decoder_validator_top utf8sdv_checker u_utf8sdv_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder and validator testbench
// Feeds byte strings through the decoder and checks every per-byte result
// against a cycle-free model of the decode state, under random handshake
// stalls, a long output stall, a paused sequence and both null policies.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8sdv_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 2000; // cycles with no transfer at all
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned SETTLE_CYCLES = 2;   // extra clocks waited once all results are taken
   localparam int unsigned HOLD_CYCLES  = 60;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   // One result as the block reports it.
   typedef struct packed {
      logic            char_done;
      logic [CP_W-1:0] code_point;
      logic            string_end;
      logic            string_valid;
   } char_result_type;

   // Ports. Every input starts at a known value.
   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_wr_en        = 1'b0;
   logic              csr_wr_data      = 1'b0;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte    = '0;
   logic              req_last_byte    = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic              rsp_char_done;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_string_end;
   logic              rsp_string_valid;

   // Decode state mirrored from the block, plus the null policy register.
   logic [REM_W-1:0]  seq_left  = '0;
   logic [CP_W-1:0]   cp_accum  = '0;
   logic              str_err   = 1'b0;
   logic              null_ok   = 1'b0;

   // Results still owed by the block, oldest first.
   char_result_type   decoded_q[$];

   // Handshake bookkeeping, updated on the falling edge.
   logic              req_taken   = 1'b0;
   int unsigned       xfer_count  = 0;
   int unsigned       result_count = 0;
   int unsigned       bytes_sent  = 0;
   int unsigned       error_count = 0;

   // Idle knobs for the two sides.
   int unsigned       req_gap_pct   = 0;
   int unsigned       rsp_stall_pct = 0;
   int unsigned       rsp_hold_left = 0;

   always #2 clock = ~clock;

   utf8_stream_decoder_validator_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_done    (rsp_char_done),
      .rsp_code_point   (rsp_code_point),
      .rsp_string_end   (rsp_string_end),
      .rsp_string_valid (rsp_string_valid)
   );

   // -------------------------------------------------------------------------
   // Decode one byte: advance the mirrored state and return the result that
   // the block owes for it.
   // -------------------------------------------------------------------------
   function automatic char_result_type decode_byte(input logic [BYTE_W-1:0] c,
                                                   input logic last);
      char_result_type  r;
      logic [REM_W-1:0] n;
      logic [6:0]       m;
      r = '0;
      if (seq_left == '0) begin
         // Lead byte: length and payload mask from the top bits.
         if (c[7] == 1'b0)               {n, m} = {3'd1, 7'h7F};
         else if (c[7:5] == 3'b110)      {n, m} = {3'd2, 7'h1F};
         else if (c[7:4] == 4'b1110)     {n, m} = {3'd3, 7'h0F};
         else if (c[7:3] == 5'b11110)    {n, m} = {3'd4, 7'h07};
         else if (c[7:2] == 6'b111110)   {n, m} = {3'd5, 7'h03};
         else if (c[7:1] == 7'b1111110)  {n, m} = {3'd6, 7'h01};
         else                            {n, m} = {3'd0, 7'h00};

         if (n == 3'd0) begin
            // undefined lead or stray continuation
            str_err = 1'b1;
         end else if (n == 3'd1) begin
            if (c == '0 && !null_ok) begin
               str_err = 1'b1;
            end else begin
               r.char_done  = 1'b1;
               r.code_point = CP_W'(c);
            end
         end else begin
            cp_accum = CP_W'(c[6:0] & m);
            seq_left = n - 3'd1;
         end
      end else if (c[7:6] != CONT_TAG) begin
         // bad continuation: drop the open sequence, the byte is consumed
         str_err  = 1'b1;
         seq_left = '0;
         cp_accum = '0;
      end else begin
         cp_accum = {cp_accum[CP_W-7:0], c[5:0]};
         seq_left = seq_left - 3'd1;
         if (seq_left == '0) begin
            r.char_done  = 1'b1;
            r.code_point = cp_accum;
            cp_accum     = '0;
         end
      end

      if (last) begin
         // a string that stops inside a sequence is invalid
         if (seq_left != '0) str_err = 1'b1;
         r.string_end   = 1'b1;
         r.string_valid = !str_err;
         seq_left = '0;
         cp_accum = '0;
         str_err  = 1'b0;
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Sample both channels on the falling edge. Inputs only move on the rising
   // edge, so what is seen here is exactly what the next rising edge
   // transfers. Predict on each byte transfer first, then check each result
   // transfer against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : scoreboard
      char_result_type got;
      char_result_type want;
      logic            rsp_taken;
      req_taken = !reset && req_valid && req_ready;
      rsp_taken = !reset && rsp_valid && rsp_ready;
      if (req_taken || rsp_taken) xfer_count++;
      if (req_taken) decoded_q.push_back(decode_byte(req_data_byte, req_last_byte));
      if (rsp_taken) begin
         got = '{rsp_char_done, rsp_code_point, rsp_string_end, rsp_string_valid};
         if (decoded_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("result %0d with nothing pending: done=%0b cp=%h end=%0b valid=%0b",
                        result_count, got.char_done, got.code_point, got.string_end,
                        got.string_valid);
         end else begin
            want = decoded_q.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("result %0d: expected %0b/%h/%0b/%0b, got %0b/%h/%0b/%0b",
                           result_count, want.char_done, want.code_point, want.string_end,
                           want.string_valid, got.char_done, got.code_point, got.string_end,
                           got.string_valid);
            end
         end
         result_count++;
      end
   end

   // Result side: random stalls, or a long hold when a test asks for one.
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (rsp_hold_left != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Drop the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet = 0;
      int unsigned seen  = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (xfer_count != seen) begin
            seen  = xfer_count;
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("utf8_stream_decoder_validator_top test failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Shared stimulus tasks
   // -------------------------------------------------------------------------

   // Offer one byte and hold it until the transfer. Valid is lowered only for
   // a random gap, so it never drops and rises in the same step.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do
         @(posedge clock);
      while (!req_taken);
      bytes_sent++;
   endtask

   // Send a whole string; the final byte carries the last flag.
   task automatic send_text(input byte_q_type text);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // Stop offering and wait until every owed result has been taken.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the null policy while the block is idle.
   task automatic write_null_policy(input logic allow);
      wait_all_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= allow;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      null_ok = allow;
   endtask

   // Build a string of mostly well-formed characters with random payloads,
   // spiced with noise bytes, zero bytes, bad continuations and truncations.
   task automatic send_string(input int unsigned n_chars);
      byte_q_type        text;
      int unsigned       pick;
      int unsigned       len;
      logic [BYTE_W-1:0] lead;
      for (int unsigned k = 0; k < n_chars; k++) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            text.push_back(BYTE_W'($urandom_range(255)));
         end else if (pick < 9) begin
            text.push_back('0);
         end else begin
            pick = $urandom_range(99);
            len  = (pick < 40) ? 1 : (pick < 60) ? 2 : (pick < 75) ? 3 :
                   (pick < 87) ? 4 : (pick < 94) ? 5 : 6;
            if (len == 1)
               lead = {1'b0, 7'($urandom)};
            else
               lead = BYTE_W'(8'hFF << (8 - len)) | (BYTE_W'($urandom) & (8'hFF >> (len + 1)));
            text.push_back(lead);
            for (int unsigned j = 1; j < len; j++) begin
               pick = $urandom_range(99);
               if (pick < 4) break;                               // cut the sequence short
               else if (pick < 8) text.push_back(BYTE_W'($urandom)); // maybe a bad one
               else text.push_back({CONT_TAG, 6'($urandom)});
            end
         end
      end
      send_text(text);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Sequences of one, two, three, four and six bytes, up to the largest code point, in one valid string.
   task automatic test_well_formed_sequences();
      byte_q_type text;
      text = {8'hC3, 8'hA9,                             // two bytes
              8'hE2, 8'h82, 8'hAC,                      // three bytes
              8'hF0, 8'h9F, 8'h98, 8'h80,               // four bytes
              8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, // six bytes, all ones
              8'h7F};                                   // largest single byte
      send_text(text);
   endtask

   // Zero byte with nulls barred, undefined leads, a stray continuation, a bad
   // continuation that is swallowed, decoding after the error, and a string
   // that stops inside a sequence.
   task automatic test_malformed_string();
      byte_q_type text;
      text = {8'h00, 8'hFE, 8'hFF, 8'h80, 8'hC3, 8'h41, 8'h7F, 8'hE2, 8'h82};
      send_text(text);
   endtask

   // With nulls allowed, zero bytes decode as characters.
   task automatic test_null_policy();
      byte_q_type text;
      write_null_policy(1'b1);
      text = {8'h00, 8'h00};
      send_text(text);
      write_null_policy(1'b0);
   endtask

   // Random strings until the phase's byte budget is spent.
   task automatic test_random_strings(input int unsigned gap_pct, input int unsigned stall_pct,
                                      input logic allow, input int unsigned n_bytes);
      int unsigned stop_at;
      write_null_policy(allow);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      stop_at       = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) send_string($urandom_range(8, 1));
   endtask

   // Hold the result side off for a long stretch while bytes keep coming, so
   // the result register fills and the input stalls.
   task automatic test_output_stall();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = HOLD_CYCLES;
      send_string(12);
      wait_all_results();
   endtask

   // Pause the sender in the middle of a sequence until everything has
   // drained; the open sequence must survive the idle stretch.
   task automatic test_mid_sequence_pause();
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      wait_all_results();
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b1);
      wait_all_results();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_well_formed_sequences();
      test_malformed_string();
      test_null_policy();

      // sender idles rarely, receiver often; then the other way round
      test_random_strings(13, 85, 1'b1, 280);
      test_random_strings(85, 13, 1'b0, 280);

      test_output_stall();
      test_mid_sequence_pause();

      // full rate on both sides
      test_random_strings(0, 0, 1'b1, 300);

      wait_all_results();
      if (error_count == 0)
         $display("utf8_stream_decoder_validator_top test passed");
      else
         $display("utf8_stream_decoder_validator_top test failed");
      $finish;
   end

endmodule

// ===== utf8_stream_decoder_validator_top.f =====
+incdir+hw/rtl
hw/rtl/utf8sdv_pkg.sv
hw/rtl/utf8_stream_decoder_validator_top.sv
hw/rtl/utf8sdv_checker.sv
test/tb.sv
